### rtl/core/nusf_pkg.sv
package nusf_pkg;

  // Largest UBX length field plus two that the block will ever accept.
  localparam int UBX_LIMIT_MAX = 1024;
  // Width of the remaining-bytes counter of a UBX frame.
  localparam int REM_W = $clog2(UBX_LIMIT_MAX + 1);

  localparam int BYTE_W     = 8;
  localparam int IDX_W      = 11;
  localparam int NMEA_LIM_W = 7;
  localparam int UBX_LIM_W  = 11;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 1;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_NMEA_LIMIT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UBX_LIMIT  = 1'd1;

  localparam logic [NMEA_LIM_W-1:0] NMEA_LIMIT_RST = 7'd80;
  localparam logic [UBX_LIM_W-1:0]  UBX_LIMIT_RST  = 11'd1024;

  // Characters and sync bytes.
  localparam logic [BYTE_W-1:0] CH_DOLLAR    = 8'h24;
  localparam logic [BYTE_W-1:0] CH_BANG      = 8'h21;
  localparam logic [BYTE_W-1:0] CH_STAR      = 8'h2a;
  localparam logic [BYTE_W-1:0] CH_PRINT_LO  = 8'h20;
  localparam logic [BYTE_W-1:0] CH_PRINT_HI  = 8'h7e;
  localparam logic [BYTE_W-1:0] UBX_SYNC1    = 8'hb5;
  localparam logic [BYTE_W-1:0] UBX_SYNC2    = 8'h62;

  // Stream kinds.
  localparam logic KIND_NMEA = 1'b0;
  localparam logic KIND_UBX  = 1'b1;

  // One result beat.
  typedef struct packed {
    logic              byte_valid;
    logic [BYTE_W-1:0] data_byte;
    logic              stream_kind;
    logic [IDX_W-1:0]  byte_index;
    logic              frame_start;
    logic              frame_end;
    logic              frame_abort;
  } res_t;

endpackage

### rtl/core/nusf_in_stage.sv
module nusf_in_stage (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [nusf_pkg::BYTE_W-1:0] in_rx_byte,
  input  logic                        take,
  output logic                        hold_valid,
  output logic [nusf_pkg::BYTE_W-1:0] hold_byte
);
  import nusf_pkg::*;

  logic              valid_r;
  logic              valid_nxt;
  logic [BYTE_W-1:0] byte_r;
  logic              load;

  // The held byte leaves whenever the parser takes it, so a new one may enter.
  assign in_ready   = !valid_r || take;
  assign load       = in_valid && in_ready;
  assign valid_nxt  = load ? 1'b1 : (take ? 1'b0 : valid_r);
  assign hold_valid = valid_r;
  assign hold_byte  = byte_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= in_rx_byte;
    end
  end

endmodule

### rtl/core/nusf_parser.sv
module nusf_parser (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            step,
  input  logic [nusf_pkg::BYTE_W-1:0]     rx_byte,
  input  logic                            cfg_write,
  input  logic [nusf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [nusf_pkg::CFG_DATA_W-1:0] cfg_data,
  output nusf_pkg::res_t                  res,
  output logic                            res_emit
);
  import nusf_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_NMEA_BODY,
    PH_NMEA_CK1,
    PH_NMEA_CK2,
    PH_NMEA_EOL,
    PH_UBX_SYNC2,
    PH_UBX_CLASS,
    PH_UBX_ID,
    PH_UBX_LEN_LO,
    PH_UBX_LEN_HI,
    PH_UBX_BODY
  } phase_t;

  phase_t                phase_r, phase_nxt;
  logic [IDX_W-1:0]      count_r, count_nxt;
  logic [BYTE_W-1:0]     len_lo_r, len_lo_nxt;
  logic [REM_W-1:0]      rem_r, rem_nxt;
  logic [NMEA_LIM_W-1:0] nmea_lim_r;
  logic [UBX_LIM_W-1:0]  ubx_lim_r;

  logic                  do_hunt;
  logic                  not_print;
  logic                  too_long;
  logic [16:0]           ubx_len;
  logic [16:0]           lim_cfg;
  logic [16:0]           lim_eff;
  logic [REM_W-1:0]      rem_dec;
  res_t                  r;

  assign not_print = (rx_byte < CH_PRINT_LO) || (rx_byte > CH_PRINT_HI);
  assign too_long  = ({1'b0, count_r} + 12'd1) >= {5'd0, nmea_lim_r};
  assign ubx_len   = {1'b0, rx_byte, len_lo_r} + 17'd2;
  assign lim_cfg   = {6'd0, ubx_lim_r};
  assign lim_eff   = (lim_cfg > 17'(UBX_LIMIT_MAX)) ? 17'(UBX_LIMIT_MAX) : lim_cfg;
  assign rem_dec   = (rem_r != '0) ? (rem_r - REM_W'(1)) : rem_r;

  always_comb begin
    r          = '0;
    do_hunt    = 1'b0;
    phase_nxt  = phase_r;
    count_nxt  = count_r;
    len_lo_nxt = len_lo_r;
    rem_nxt    = rem_r;

    case (phase_r)
      PH_NMEA_BODY: begin
        if (not_print || too_long) begin
          r.frame_abort = 1'b1;
          do_hunt       = 1'b1;
        end else begin
          r.byte_valid  = 1'b1;
          r.data_byte   = rx_byte;
          r.stream_kind = KIND_NMEA;
          r.byte_index  = count_r;
          count_nxt     = count_r + IDX_W'(1);
          if (rx_byte == CH_STAR) begin
            phase_nxt = PH_NMEA_CK1;
          end
        end
      end
      PH_NMEA_CK1, PH_NMEA_CK2: begin
        r.byte_valid  = 1'b1;
        r.data_byte   = rx_byte;
        r.stream_kind = KIND_NMEA;
        r.byte_index  = count_r;
        count_nxt     = count_r + IDX_W'(1);
        if (phase_r == PH_NMEA_CK1) begin
          phase_nxt = PH_NMEA_CK2;
        end else begin
          r.frame_end = 1'b1;
          phase_nxt   = PH_NMEA_EOL;
        end
      end
      PH_NMEA_EOL: begin
        // The line end is swallowed.
        phase_nxt = PH_IDLE;
        count_nxt = '0;
        rem_nxt   = '0;
      end
      PH_UBX_SYNC2: begin
        if (rx_byte != UBX_SYNC2) begin
          r.frame_abort = 1'b1;
          do_hunt       = 1'b1;
        end else begin
          r.byte_valid  = 1'b1;
          r.data_byte   = rx_byte;
          r.stream_kind = KIND_UBX;
          r.byte_index  = IDX_W'(1);
          count_nxt     = IDX_W'(2);
          phase_nxt     = PH_UBX_CLASS;
        end
      end
      PH_UBX_CLASS, PH_UBX_ID: begin
        r.byte_valid  = 1'b1;
        r.data_byte   = rx_byte;
        r.stream_kind = KIND_UBX;
        r.byte_index  = count_r;
        count_nxt     = count_r + IDX_W'(1);
        phase_nxt     = (phase_r == PH_UBX_CLASS) ? PH_UBX_ID : PH_UBX_LEN_LO;
      end
      PH_UBX_LEN_LO: begin
        r.byte_valid  = 1'b1;
        r.data_byte   = rx_byte;
        r.stream_kind = KIND_UBX;
        r.byte_index  = IDX_W'(4);
        len_lo_nxt    = rx_byte;
        count_nxt     = IDX_W'(5);
        phase_nxt     = PH_UBX_LEN_HI;
      end
      PH_UBX_LEN_HI: begin
        if (ubx_len > lim_eff) begin
          r.frame_abort = 1'b1;
          do_hunt       = 1'b1;
        end else begin
          r.byte_valid  = 1'b1;
          r.data_byte   = rx_byte;
          r.stream_kind = KIND_UBX;
          r.byte_index  = IDX_W'(5);
          count_nxt     = IDX_W'(6);
          rem_nxt       = ubx_len[REM_W-1:0];
          phase_nxt     = PH_UBX_BODY;
        end
      end
      PH_UBX_BODY: begin
        r.byte_valid  = 1'b1;
        r.data_byte   = rx_byte;
        r.stream_kind = KIND_UBX;
        r.byte_index  = count_r;
        if (rem_dec == '0) begin
          r.frame_end = 1'b1;
          phase_nxt   = PH_IDLE;
          count_nxt   = '0;
          rem_nxt     = '0;
        end else begin
          count_nxt = count_r + IDX_W'(1);
          rem_nxt   = rem_dec;
        end
      end
      default: begin
        do_hunt = 1'b1;
      end
    endcase

    // Start search, also for a byte that just aborted a frame.
    if (do_hunt) begin
      phase_nxt = PH_IDLE;
      count_nxt = '0;
      rem_nxt   = '0;
      if (rx_byte == CH_DOLLAR || rx_byte == CH_BANG) begin
        r.byte_valid  = 1'b1;
        r.data_byte   = rx_byte;
        r.stream_kind = KIND_NMEA;
        r.byte_index  = '0;
        r.frame_start = 1'b1;
        phase_nxt     = PH_NMEA_BODY;
        count_nxt     = IDX_W'(1);
      end else if (rx_byte == UBX_SYNC1) begin
        r.byte_valid  = 1'b1;
        r.data_byte   = rx_byte;
        r.stream_kind = KIND_UBX;
        r.byte_index  = '0;
        r.frame_start = 1'b1;
        phase_nxt     = PH_UBX_SYNC2;
        count_nxt     = IDX_W'(1);
      end
    end
  end

  assign res      = r;
  assign res_emit = r.byte_valid || r.frame_abort;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      count_r    <= '0;
      len_lo_r   <= '0;
      rem_r      <= '0;
      nmea_lim_r <= NMEA_LIMIT_RST;
      ubx_lim_r  <= UBX_LIMIT_RST;
    end else begin
      if (step) begin
        phase_r  <= phase_nxt;
        count_r  <= count_nxt;
        len_lo_r <= len_lo_nxt;
        rem_r    <= rem_nxt;
      end
      if (cfg_write) begin
        case (cfg_index)
          CFG_NMEA_LIMIT: nmea_lim_r <= cfg_data[NMEA_LIM_W-1:0];
          CFG_UBX_LIMIT:  ubx_lim_r  <= cfg_data[UBX_LIM_W-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

### rtl/core/nusf_out_stage.sv
module nusf_out_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           load_req,
  input  nusf_pkg::res_t res_in,
  output logic           free,
  output logic           out_valid,
  input  logic           out_ready,
  output nusf_pkg::res_t res_out
);
  import nusf_pkg::*;

  logic valid_r;
  logic valid_nxt;
  res_t res_r;

  // The register can take a beat when empty or when its beat leaves now.
  assign free      = !valid_r || out_ready;
  assign valid_nxt = free ? load_req : valid_r;
  assign out_valid = valid_r;
  assign res_out   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load_req) begin
      res_r <= res_in;
    end
  end

endmodule

### rtl/core/nmea_ubx_stream_framer.sv
// Path: a byte accepted at a rising edge is held in the input register and parsed from there, and
// its result beat is registered in the output register, ready to be taken from there on.
// Throughput: one byte per cycle; a result beat held by out_ready low stalls the input.
// Reset (rst_n, synchronous, active low) empties both registers, returns the parser to
// start search and loads the length limits with 80 and 1024; no clearing pass is needed.
module nmea_ubx_stream_framer (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [nusf_pkg::BYTE_W-1:0]     in_rx_byte,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_byte_valid,
  output logic [nusf_pkg::BYTE_W-1:0]     out_data_byte,
  output logic                            out_stream_kind,
  output logic [nusf_pkg::IDX_W-1:0]      out_byte_index,
  output logic                            out_frame_start,
  output logic                            out_frame_end,
  output logic                            out_frame_abort,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [nusf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [nusf_pkg::CFG_DATA_W-1:0] cfg_data
);
  import nusf_pkg::*;

  logic              hold_valid;
  logic [BYTE_W-1:0] hold_byte;
  logic              out_free;
  logic              step;
  logic              res_emit;
  res_t              res;
  res_t              res_q;

  // Configuration writes are always taken; the user must issue them only while idle (unchecked).
  assign cfg_ready = 1'b1;

  // The parser steps on the held byte whenever the output register can take
  // its beat. Bytes that make no beat (idle noise, the NMEA line end) still
  // step the parser and simply leave the output register alone.
  assign step = hold_valid && out_free;

  nusf_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .take       (out_free),
    .hold_valid (hold_valid),
    .hold_byte  (hold_byte)
  );

  nusf_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .rx_byte   (hold_byte),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .res       (res),
    .res_emit  (res_emit)
  );

  nusf_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load_req  (step && res_emit),
    .res_in    (res),
    .free      (out_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res_out   (res_q)
  );

  assign out_byte_valid  = res_q.byte_valid;
  assign out_data_byte   = res_q.data_byte;
  assign out_stream_kind = res_q.stream_kind;
  assign out_byte_index  = res_q.byte_index;
  assign out_frame_start = res_q.frame_start;
  assign out_frame_end   = res_q.frame_end;
  assign out_frame_abort = res_q.frame_abort;

  // A held byte behind a stalled result beat must back-pressure the input.
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    (hold_valid && out_valid && !out_ready) |-> !in_ready)
    else $error("input accepted while both stages are full and stalled");

  // Every beat carries either a frame byte or an abort mark.
  a_no_empty_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_byte_valid || out_frame_abort))
    else $error("empty result beat");

  // A frame start is always the first, valid byte of its frame.
  a_start_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_frame_start) |-> (out_byte_valid && out_byte_index == '0))
    else $error("frame start with nonzero index");

endmodule
